>>> src/oaht_pkg.sv
// Shared constants, codes and controller/datapath interface types for the hash table.
`default_nettype none

package oaht_pkg;

  localparam int unsigned TABLE_SIZE = 64;
  localparam int unsigned ADDR_W     = $clog2(TABLE_SIZE);
  localparam int unsigned COUNT_W    = ADDR_W + 1;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned ENTRY_W    = 2 + KEY_W + VAL_W;

  // golden-ratio fraction, unsigned 0.32
  localparam logic [KEY_W-1:0] GOLDEN_FRAC = 32'h9E37_79B9;

  // probe step for i = 1 is 5+3 = 8; its first difference 6*1+8 = 14, then +6 per probe
  localparam logic [ADDR_W-1:0] INC_INIT   = ADDR_W'(8);
  localparam logic [ADDR_W-1:0] DINC_INIT  = ADDR_W'(14);
  localparam logic [ADDR_W-1:0] DINC_STEP  = ADDR_W'(6);
  localparam logic [ADDR_W-1:0] LAST_PROBE = ADDR_W'(TABLE_SIZE - 1);

  // operation codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  // result codes
  localparam logic [1:0] RES_OK        = 2'd0;
  localparam logic [1:0] RES_NOT_FOUND = 2'd1;
  localparam logic [1:0] RES_NO_SLOT   = 2'd2;

  // slot states
  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_USED    = 2'd1;
  localparam logic [1:0] ST_DELETED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_DONE
  } oaht_state_e;

  typedef struct packed {
    logic       load_in;   // capture the input transaction
    logic       hash;      // compute home slot, reset probe counters
    logic       rd;        // read slot memory at current probe
    logic       wr_used;   // store new entry at current probe
    logic       wr_tomb;   // turn current slot into a tombstone
    logic       advance;   // step to next probe
    logic       res_set;   // latch result code
    logic [1:0] res_code;
    logic       res_val;   // result carries slot payload
    logic       out_load;  // move result into output register
  } oaht_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       full;
    logic       rd_used;
    logic       rd_empty;
    logic       key_match;
    logic       last_probe;
    logic       out_free;
  } oaht_stat_t;

endpackage

`default_nettype wire

>>> src/oaht_ctrl.sv
// Operation sequencer: walks the probe chain and drives the datapath.
`default_nettype none

module oaht_ctrl import oaht_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  oaht_stat_t  stat_i,
  output oaht_cmd_t   cmd_o
);

  oaht_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  logic is_insert, is_lookup;
  assign is_insert = (stat_i.act == ACT_INSERT);
  assign is_lookup = (stat_i.act == ACT_SEARCH) || (stat_i.act == ACT_DELETE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_HASH;
      end
      S_HASH: begin
        if ((is_insert && !stat_i.full) || is_lookup) state_d = S_READ;
        else state_d = S_DONE;
      end
      S_READ: state_d = S_CHECK;
      S_CHECK: begin
        if (is_insert) begin
          if (!stat_i.rd_used || stat_i.last_probe) state_d = S_DONE;
          else state_d = S_READ;
        end else begin
          if (stat_i.rd_empty || (stat_i.rd_used && stat_i.key_match) || stat_i.last_probe) begin
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_HASH: begin
        cmd_o.hash = 1'b1;
        if (is_insert && stat_i.full) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = RES_NO_SLOT;
        end else if (!is_insert && !is_lookup) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = RES_NOT_FOUND;
        end
      end
      S_READ: cmd_o.rd = 1'b1;
      S_CHECK: begin
        if (is_insert) begin
          if (!stat_i.rd_used) begin
            cmd_o.wr_used  = 1'b1;
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = RES_OK;
          end else if (stat_i.last_probe) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = RES_NO_SLOT;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end else begin
          if (stat_i.rd_empty) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = RES_NOT_FOUND;
          end else if (stat_i.rd_used && stat_i.key_match) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = RES_OK;
            cmd_o.res_val  = 1'b1;
            cmd_o.wr_tomb  = (stat_i.act == ACT_DELETE);
          end else if (stat_i.last_probe) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = RES_NOT_FOUND;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      S_DONE: cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/oaht_datapath.sv
// Slot memory, hash, probe sequence, entry count and result/output registers.
`default_nettype none

module oaht_datapath import oaht_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  oaht_cmd_t         cmd_i,
  output oaht_stat_t        stat_o,
  input  wire [1:0]         in_act_i,
  input  wire [KEY_W-1:0]   in_key_i,
  input  wire [VAL_W-1:0]   in_val_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [1:0]        out_status_o,
  output logic [ADDR_W-1:0] out_slot_o,
  output logic [VAL_W-1:0]  out_val_o
);

  // captured transaction
  logic [1:0]       act_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q <= in_act_i;
      key_q <= in_key_i;
      val_q <= in_val_i;
    end
  end

  // multiplicative hash: top bits of the 0.32 fraction of key * golden ratio
  logic [KEY_W-1:0]  frac;
  logic [ADDR_W-1:0] home;
  assign frac = key_q * GOLDEN_FRAC;
  assign home = frac[KEY_W-1 -: ADDR_W];

  // probe walk: j += 5i + 3i^2, kept incrementally mod table size
  logic [ADDR_W-1:0] j_q, i_q, inc_q, dinc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hash) begin
      j_q    <= home;
      i_q    <= '0;
      inc_q  <= INC_INIT;
      dinc_q <= DINC_INIT;
    end else if (cmd_i.advance) begin
      j_q    <= j_q + inc_q;
      i_q    <= i_q + ADDR_W'(1);
      inc_q  <= inc_q + dinc_q;
      dinc_q <= dinc_q + DINC_STEP;
    end
  end

  // slot memory {state, key, payload}; per-slot written flags stand in for a clear
  logic [ENTRY_W-1:0]    mem [TABLE_SIZE];
  logic [ENTRY_W-1:0]    rd_q;
  logic [TABLE_SIZE-1:0] written_q;
  logic                  rd_written_q;
  logic [ENTRY_W-1:0]    wdata;
  logic                  wr;

  logic [1:0]       rd_state;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  assign rd_state = rd_q[ENTRY_W-1 -: 2];
  assign rd_key   = rd_q[VAL_W +: KEY_W];
  assign rd_val   = rd_q[VAL_W-1:0];

  assign wr    = cmd_i.wr_used || cmd_i.wr_tomb;
  assign wdata = cmd_i.wr_used ? {ST_USED, key_q, val_q} : {ST_DELETED, rd_key, rd_val};

  always_ff @(posedge clk_i) begin
    if (wr) mem[j_q] <= wdata;
    if (cmd_i.rd) rd_q <= mem[j_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr) written_q[j_q] <= 1'b1;
      if (cmd_i.rd) rd_written_q <= written_q[j_q];
    end
  end

  // used-slot count
  logic [COUNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.wr_used) begin
      count_q <= count_q + COUNT_W'(1);
    end else if (cmd_i.wr_tomb && count_q != '0) begin
      count_q <= count_q - COUNT_W'(1);
    end
  end

  // result register
  logic [1:0]        res_status_q;
  logic [ADDR_W-1:0] res_slot_q;
  logic [VAL_W-1:0]  res_val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_code;
      res_slot_q   <= (cmd_i.res_code == RES_OK) ? j_q : '0;
      res_val_q    <= cmd_i.res_val ? rd_val : '0;
    end
  end

  // output register
  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [ADDR_W-1:0] out_slot_q;
  logic [VAL_W-1:0]  out_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_val_q    <= res_val_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_val_o    = out_val_q;

  assign stat_o.act        = act_q;
  assign stat_o.full       = (count_q == COUNT_W'(TABLE_SIZE));
  assign stat_o.rd_used    = rd_written_q && (rd_state == ST_USED);
  assign stat_o.rd_empty   = !rd_written_q || (rd_state == ST_EMPTY);
  assign stat_o.key_match  = (rd_key == key_q);
  assign stat_o.last_probe = (i_q == LAST_PROBE);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

>>> src/open_address_hash_table_core.sv
// Sequence: accept, hash to the home slot, walk 1..64 probes, then load the output register;
// an unknown action or an insert into a full table skips the walk.
// Each probe is one slot-memory read plus one check; the single memory port sets the pace.
// One transaction is in flight at a time;
// a new one is taken once the result moves into the output register, even while it waits there.
// Reset: all slots read as empty and the entry count is zero at once; no clearing pass.
`default_nettype none

module open_address_hash_table_core import oaht_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  // request channel
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [63:0]  s_axis_tdata,   // [31:0] key, [63:32] value
  input  wire [1:0]   s_axis_tuser,   // [1:0] action
  // response channel
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [5:0] slot, [37:6] found_value, [39:38] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  oaht_cmd_t  cmd;
  oaht_stat_t stat;

  logic [ADDR_W-1:0] out_slot;
  logic [VAL_W-1:0]  out_val;
  logic [1:0]        out_status;

  // controller: one transaction at a time, a read state and a check state per probe
  oaht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: hash, probe walk, slot memory, result and output registers
  oaht_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_act_i     (s_axis_tuser),
    .in_key_i     (s_axis_tdata[31:0]),
    .in_val_i     (s_axis_tdata[63:32]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_slot_o   (out_slot),
    .out_val_o    (out_val)
  );

  assign m_axis_tdata = {2'b00, out_val, out_slot};
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the open-addressing hash table core.
module testbench;
  import oaht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNKNOWN   = 2'd3;
  localparam int         NUM_DIRECTED  = 20;
  localparam int         RANDOM_ITEMS  = 450;
  localparam int         KEY_POOL      = 64;
  localparam int         DRAIN_CYCLES  = 3 + 2 * TABLE_SIZE + 10;
  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam int         REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] slot;
    logic [VAL_W-1:0]  fval;
  } hash_result_t;

  typedef struct packed {
    logic [1:0]       act;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             typed;   // want holds a hand-written answer
    hash_result_t     want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [31:0] key, [63:32] value
  logic [1:0]  s_axis_tuser;   // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [5:0] slot, [37:6] found_value, [39:38] zero
  logic [1:0]  m_axis_tuser;   // [1:0] status

  open_address_hash_table_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow copy of the table
  logic [1:0]       tbl_state   [TABLE_SIZE];
  logic [KEY_W-1:0] tbl_key     [TABLE_SIZE];
  logic [VAL_W-1:0] tbl_payload [TABLE_SIZE];
  int unsigned      tbl_count;

  hash_result_t     expected_results [$];
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  int               mismatches;
  int unsigned      cycle_count;
  bit               no_idle;

  // Directed opening: empty-table misses, unknown action, extremes of key and
  // value, duplicate keys, tombstone reuse and search through a tombstone.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{ACT_SEARCH,  32'h0000_0000, 32'h0000_0000, 1'b1, '{RES_NOT_FOUND, 6'd0, 32'h0}},
    '{ACT_DELETE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{RES_NOT_FOUND, 6'd0, 32'h0}},
    '{ACT_UNKNOWN, 32'h0000_0000, 32'h0000_0000, 1'b1, '{RES_NOT_FOUND, 6'd0, 32'h0}},
    // key 0 hashes to slot 0
    '{ACT_INSERT,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{RES_OK, 6'd0, 32'h0}},
    '{ACT_INSERT,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{ACT_SEARCH,  32'h0000_0000, 32'h0000_0000, 1'b1, '{RES_OK, 6'd0, 32'hFFFF_FFFF}},
    '{ACT_INSERT,  32'h0000_0000, 32'h1234_5678, 1'b0, '0},
    // duplicate key: first match on the chain wins
    '{ACT_SEARCH,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{RES_OK, 6'd0, 32'hFFFF_FFFF}},
    '{ACT_DELETE,  32'h0000_0000, 32'h0000_0000, 1'b1, '{RES_OK, 6'd0, 32'hFFFF_FFFF}},
    '{ACT_SEARCH,  32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{ACT_INSERT,  32'h0000_0000, 32'hA5A5_A5A5, 1'b0, '0},
    '{ACT_DELETE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_DELETE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{ACT_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{RES_NOT_FOUND, 6'd0, 32'h0}},
    '{ACT_SEARCH,  32'h8000_0000, 32'h0000_0000, 1'b0, '0},
    '{ACT_INSERT,  32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{ACT_INSERT,  32'h0000_0001, 32'h0000_0001, 1'b0, '0},
    '{ACT_SEARCH,  32'h0000_0001, 32'h0000_0000, 1'b0, '0},
    '{ACT_DELETE,  32'h8000_0000, 32'h5A5A_5A5A, 1'b0, '0},
    '{ACT_SEARCH,  32'h8000_0000, 32'h0000_0000, 1'b0, '0}
  };

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Home slot: top ADDR_W bits of the 0.32 fraction of key * golden ratio
  function automatic logic [ADDR_W-1:0] home_of(logic [KEY_W-1:0] key);
    logic [63:0] prod;
    prod = 64'(key) * 64'(GOLDEN_FRAC);
    return prod[31 -: ADDR_W];
  endfunction

  // Applies one operation to the shadow table and returns its result.
  function automatic hash_result_t apply_op(logic [1:0] act, logic [KEY_W-1:0] key,
                                            logic [VAL_W-1:0] value);
    hash_result_t      res;
    logic [ADDR_W-1:0] j;
    res = '{RES_NOT_FOUND, '0, '0};
    j   = home_of(key);
    if (act == ACT_INSERT) begin
      res.status = RES_NO_SLOT;
      if (tbl_count != TABLE_SIZE) begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
          // step 5i + 3i^2, wraps modulo the table size
          if (i != 0) j = j + ADDR_W'(5 * i + 3 * i * i);
          if (tbl_state[j] != ST_USED) begin
            tbl_state[j]   = ST_USED;
            tbl_key[j]     = key;
            tbl_payload[j] = value;
            tbl_count++;
            res.status = RES_OK;
            res.slot   = j;
            break;
          end
        end
      end
    end else if (act == ACT_SEARCH || act == ACT_DELETE) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (i != 0) j = j + ADDR_W'(5 * i + 3 * i * i);
        if (tbl_state[j] == ST_EMPTY) break;
        if (tbl_state[j] == ST_USED && tbl_key[j] == key) begin
          res.status = RES_OK;
          res.slot   = j;
          res.fval   = tbl_payload[j];
          if (act == ACT_DELETE) begin
            tbl_state[j] = ST_DELETED;
            if (tbl_count != 0) tbl_count--;
          end
          break;
        end
      end
    end
    return res;
  endfunction

  // Mostly short gaps, a few long ones; none during no-idle stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Key of some live entry, or the fallback when the table is empty
  function automatic logic [KEY_W-1:0] stored_key_or(logic [KEY_W-1:0] fallback);
    int start;
    start = $urandom_range(0, TABLE_SIZE - 1);
    for (int k = 0; k < TABLE_SIZE; k++) begin
      if (tbl_state[(start + k) % TABLE_SIZE] == ST_USED)
        return tbl_key[(start + k) % TABLE_SIZE];
    end
    return fallback;
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  // Drives one request and records its expected response once accepted.
  task automatic send_op(input logic [1:0] act, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] value, input logic typed,
                         input hash_result_t want);
    int           gap;
    hash_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {value, key};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_op(act, key, value);
    expected_results.push_back(typed ? want : predicted);
  endtask

  initial begin
    logic [1:0]       act;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] fresh;
    int               r;
    bit               filling;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    no_idle       = 1'b0;
    mismatches    = 0;
    tbl_count     = 0;
    foreach (tbl_state[k]) begin
      tbl_state[k]   = ST_EMPTY;
      tbl_key[k]     = '0;
      tbl_payload[k] = '0;
    end
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    for (int k = 3; k < KEY_POOL; k++) key_pool[k] = $urandom;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k])
      send_op(directed_rows[k].act, directed_rows[k].key, directed_rows[k].value,
              directed_rows[k].typed, directed_rows[k].want);

    // Alternating fill and drain phases push the table to full, through
    // chain exhaustion near full load, and back down through tombstones.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = ((n / 40) % 4 == 3);
      filling = ((n / 90) % 2 == 0);
      r = $urandom_range(0, 99);
      if (r < 3)        act = ACT_UNKNOWN;
      else if (filling) act = (r < 80) ? ACT_INSERT : (r < 93) ? ACT_SEARCH : ACT_DELETE;
      else              act = (r < 22) ? ACT_INSERT : (r < 50) ? ACT_SEARCH : ACT_DELETE;
      fresh = $urandom_range(0, 1) ? $urandom : key_pool[$urandom_range(0, KEY_POOL - 1)];
      if (act == ACT_SEARCH || act == ACT_DELETE)
        key = ($urandom_range(0, 9) < 8) ? stored_key_or(fresh) : fresh;
      else
        key = fresh;
      send_op(act, key, $urandom, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Response side back-pressure
  initial begin
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Response checker: one transaction per handshake against the oldest expectation
  always @(posedge clk_i) begin
    hash_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("response with nothing pending: status %0d tdata %h",
                                m_axis_tuser, m_axis_tdata));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.status)
          note_mismatch($sformatf("status exp %0d got %0d", want.status, m_axis_tuser));
        if (m_axis_tdata[ADDR_W-1:0] !== want.slot)
          note_mismatch($sformatf("slot exp %0d got %0d", want.slot,
                                  m_axis_tdata[ADDR_W-1:0]));
        if (m_axis_tdata[ADDR_W +: VAL_W] !== want.fval)
          note_mismatch($sformatf("found_value exp %h got %h", want.fval,
                                  m_axis_tdata[ADDR_W +: VAL_W]));
        if (m_axis_tdata[39:ADDR_W+VAL_W] !== '0)
          note_mismatch($sformatf("pad bits exp 0 got %b", m_axis_tdata[39:ADDR_W+VAL_W]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

>>> files.f
src/oaht_pkg.sv
src/oaht_ctrl.sv
src/oaht_datapath.sv
src/open_address_hash_table_core.sv
dv/testbench.sv
